>>> design/ack_rt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_rt_pkg
// Shared types and constants of the acknowledgement retransmission table.
// ----------------------------------------------------------------------------
package ack_rt_pkg;

   localparam int ENTRIES      = 16;
   localparam int CNT_W        = $clog2(ENTRIES + 1);
   localparam int SEQ_W        = 32;
   localparam int TAG_W        = 16;
   localparam int TIME_W       = 32;
   localparam int TIMEOUT_W    = 16;
   localparam int RESENDS_W    = 3;
   localparam int REMOVED_W    = 5;
   localparam int REMOVED_MAX  = 31;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = TIMEOUT_W'(100);
   localparam logic [RESENDS_W-1:0] MAX_RESENDS_RESET = RESENDS_W'(5);

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RESENDS = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ACT_TRACK = 2'd0,
      ACT_ACK   = 2'd1,
      ACT_SCAN  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRACK,
      S_ACK_RING,
      S_COLLAPSE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0]     seq;
      logic [TAG_W-1:0]     tag;
      logic [TIME_W-1:0]    sent;
      logic [RESENDS_W-1:0] resends;
   } body_type;

   typedef struct packed {
      logic     valid;
      body_type body;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic collapse;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 resend_valid;
      logic [SEQ_W-1:0]     seq_out;
      logic [TAG_W-1:0]     tag_out;
      logic [RESENDS_W-1:0] attempt;
      logic                 status;
      logic [REMOVED_W-1:0] removed_count;
      logic                 last;
   } rsp_type;

endpackage

>>> design/ack_rt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_rt_req_if
// Request channel: track, acknowledge or scan commands.
// ----------------------------------------------------------------------------
interface ack_rt_req_if;
   import ack_rt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [SEQ_W-1:0]     seq;
   logic [TAG_W-1:0]     packet_tag;
   logic [TIME_W-1:0]    now_ms;

   modport source (output valid, action, seq, packet_tag, now_ms, input ready);
   modport sink   (input valid, action, seq, packet_tag, now_ms, output ready);
endinterface

>>> design/ack_rt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_rt_rsp_if
// Response channel: resend beats and closing beats.
// ----------------------------------------------------------------------------
interface ack_rt_rsp_if;
   import ack_rt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 resend_valid;
   logic [SEQ_W-1:0]     seq_out;
   logic [TAG_W-1:0]     tag_out;
   logic [RESENDS_W-1:0] attempt;
   logic                 status;
   logic [REMOVED_W-1:0] removed_count;
   logic                 last;

   modport source (output valid, resend_valid, seq_out, tag_out, attempt, status,
                   removed_count, last, input ready);
   modport sink   (input valid, resend_valid, seq_out, tag_out, attempt, status,
                   removed_count, last, output ready);
endinterface

>>> design/ack_rt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_rt_cell
// One table slot; loads a new entry, takes its neighbour's entry on a ring
// shift, or pulls it up while a hole lies at or ahead of it.
// ----------------------------------------------------------------------------
module ack_rt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  ack_rt_pkg::cell_ctrl_type ctrl,
   input  ack_rt_pkg::entry_type     load_entry,
   input  ack_rt_pkg::entry_type     nb_entry,
   input  logic                      hole_in,
   output ack_rt_pkg::entry_type     entry,
   output logic                      hole_out
);
   import ack_rt_pkg::*;

   logic     valid_ff, valid_in;
   body_type body_ff, body_in;
   logic     pull;

   // a hole here or earlier means everything from here on moves up one
   assign pull = ctrl.collapse && (hole_in || !valid_ff);

   always_comb begin
      valid_in = valid_ff;
      body_in  = body_ff;
      if (ctrl.load) begin
         valid_in = load_entry.valid;
         body_in  = load_entry.body;
      end else if (ctrl.shift || pull) begin
         valid_in = nb_entry.valid;
         body_in  = nb_entry.body;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

   assign entry.valid = valid_ff;
   assign entry.body  = body_ff;
   assign hole_out    = hole_in || !valid_ff;

endmodule

>>> design/ack_rt_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_rt_head
// Head-of-ring processing: sequence match for acknowledges, timeout test
// and restamp for scans. The updated entry goes back in at the tail.
// ----------------------------------------------------------------------------
module ack_rt_head (
   input  logic                                  scan_mode,
   input  ack_rt_pkg::entry_type                 head_entry,
   input  logic [ack_rt_pkg::SEQ_W-1:0]          req_seq,
   input  logic [ack_rt_pkg::TIME_W-1:0]         now_ms,
   input  logic [ack_rt_pkg::TIMEOUT_W-1:0]      timeout_ms,
   input  logic [ack_rt_pkg::RESENDS_W-1:0]      max_resends,
   output ack_rt_pkg::entry_type                 back_entry,
   output logic                                  hit
);
   import ack_rt_pkg::*;

   logic [TIME_W-1:0] elapsed;
   logic              expired;
   logic              match;

   assign elapsed = now_ms - head_entry.body.sent;
   assign expired = head_entry.valid
                    && (elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_ms})
                    && (head_entry.body.resends < max_resends);
   assign match   = head_entry.valid && (head_entry.body.seq == req_seq);

   always_comb begin
      back_entry = head_entry;
      if (scan_mode) begin
         hit = expired;
         if (expired) begin
            back_entry.body.sent    = now_ms;
            back_entry.body.resends = head_entry.body.resends + RESENDS_W'(1);
         end
      end else begin
         hit = match;
         // acknowledged entries go back as holes, squeezed out afterwards
         if (match) begin
            back_entry.valid = 1'b0;
         end
      end
   end

endmodule

>>> design/ack_retransmit_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_retransmit_table
// Ordered table of sent packets awaiting acknowledgement, kept in a ring of
// cells that rotates through one head unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command per beat: track appends an entry stamped with
//   now_ms unless the table is full, acknowledge removes all entries with
//   the given sequence, scan emits a beat for every timed-out entry below
//   the resend limit in table order. Every command ends with exactly one
//   beat on rsp_ch with last set. csr_* writes the timeout (index 0) and
//   resend limit (index 1); the user must write only while idle, which
//   the block does not enforce.
// Operation (ENTRIES cells): acknowledge makes one ring rotation through
//   the head, then a squeeze pass; scan makes one rotation, pausing under
//   rsp back-pressure. One command is in flight at a time.
// Reset: table emptied, timeout 100 ms, resend limit 5, no beat pending.
// Stalls: the response register holds its beat while rsp_ch.ready is low;
//   during a scan the ring stops on an expired entry until the previous
//   beat has left.
// ----------------------------------------------------------------------------
module ack_retransmit_table (
   input  logic                                 clock,
   input  logic                                 reset,
   ack_rt_req_if.sink                           req_ch,
   ack_rt_rsp_if.source                         rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [ack_rt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ack_rt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ack_rt_pkg::*;

   state_type state_ff, state_in;

   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [RESENDS_W-1:0] max_resends_ff, max_resends_in;

   logic [SEQ_W-1:0]  seq_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [TIME_W-1:0] now_ff;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic             status_ff, status_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic req_accept;
   logic out_free;
   logic last_step;
   logic full;

   logic ring_shift;
   logic collapse;
   logic step_adv;
   logic track_load;
   logic emit_resend;
   logic emit_close;

   entry_type     cells   [ENTRIES];
   logic          holes   [ENTRIES+1];
   cell_ctrl_type ctrls   [ENTRIES];
   entry_type     new_entry;
   entry_type     tail_in;
   entry_type     back_entry;
   logic          head_hit;
   logic [31:0]   removed_wide;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign last_step  = (step_ff == CNT_W'(ENTRIES - 1));
   assign full       = (fill_ff == CNT_W'(ENTRIES));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (action_type'(req_ch.action))
                  ACT_TRACK: state_in = S_TRACK;
                  ACT_ACK:   state_in = S_ACK_RING;
                  ACT_SCAN:  state_in = S_SCAN;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_TRACK:    state_in = S_FINISH;
         S_ACK_RING: if (last_step) state_in = S_COLLAPSE;
         S_COLLAPSE: if (last_step) state_in = S_FINISH;
         S_SCAN:     if (ring_shift && last_step) state_in = S_FINISH;
         S_FINISH:   if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ch.ready = 1'b0;
      ring_shift   = 1'b0;
      collapse     = 1'b0;
      track_load   = 1'b0;
      emit_resend  = 1'b0;
      emit_close   = 1'b0;
      case (state_ff)
         S_IDLE:     req_ch.ready = 1'b1;
         S_TRACK:    track_load   = !full;
         S_ACK_RING: ring_shift   = 1'b1;
         S_COLLAPSE: collapse     = 1'b1;
         S_SCAN: begin
            ring_shift  = !head_hit || out_free;
            emit_resend = head_hit && out_free;
         end
         S_FINISH:   emit_close   = out_free;
         default: begin
            ring_shift = 1'b0;
         end
      endcase
   end

   assign step_adv = ring_shift || collapse;

   // head unit and the cell chain
   ack_rt_head u_head (
      .scan_mode   (state_ff == S_SCAN),
      .head_entry  (cells[0]),
      .req_seq     (seq_ff),
      .now_ms      (now_ff),
      .timeout_ms  (timeout_ff),
      .max_resends (max_resends_ff),
      .back_entry  (back_entry),
      .hit         (head_hit)
   );

   always_comb begin
      new_entry.valid        = 1'b1;
      new_entry.body.seq     = seq_ff;
      new_entry.body.tag     = tag_ff;
      new_entry.body.sent    = now_ff;
      new_entry.body.resends = '0;
      tail_in                = back_entry;
      if (collapse) begin
         tail_in.valid = 1'b0;
      end
   end

   assign holes[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type nb;
      if (i == ENTRIES - 1) begin : g_tail
         assign nb = tail_in;
      end else begin : g_mid
         assign nb = cells[i+1];
      end

      assign ctrls[i].load     = track_load && (fill_ff == CNT_W'(i));
      assign ctrls[i].shift    = ring_shift;
      assign ctrls[i].collapse = collapse;

      ack_rt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrls[i]),
         .load_entry (new_entry),
         .nb_entry   (nb),
         .hole_in    (holes[i]),
         .entry      (cells[i]),
         .hole_out   (holes[i+1])
      );
   end

   // counters and flags
   always_comb begin
      fill_in    = fill_ff;
      step_in    = step_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      if (req_accept) begin
         step_in    = '0;
         removed_in = '0;
         status_in  = 1'b0;
      end else begin
         if (step_adv) begin
            step_in = last_step ? '0 : step_ff + CNT_W'(1);
         end
         if (state_ff == S_ACK_RING && head_hit) begin
            removed_in = removed_ff + CNT_W'(1);
         end
         if (state_ff == S_COLLAPSE && last_step) begin
            fill_in = fill_ff - removed_ff;
         end
         if (state_ff == S_TRACK) begin
            status_in = full;
            if (!full) begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
      end
   end

   // configuration registers
   always_comb begin
      timeout_in     = timeout_ff;
      max_resends_in = max_resends_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMEOUT:     timeout_in     = csr_wdata[TIMEOUT_W-1:0];
            CSR_MAX_RESENDS: max_resends_in = csr_wdata[RESENDS_W-1:0];
            default:         timeout_in     = timeout_ff;
         endcase
      end
   end

   // response register
   assign removed_wide = {{(32-CNT_W){1'b0}}, removed_ff};

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (emit_resend) begin
         rsp_in.resend_valid  = 1'b1;
         rsp_in.seq_out       = cells[0].body.seq;
         rsp_in.tag_out       = cells[0].body.tag;
         rsp_in.attempt       = back_entry.body.resends;
         rsp_in.status        = 1'b0;
         rsp_in.removed_count = '0;
         rsp_in.last          = 1'b0;
         rsp_valid_in         = 1'b1;
      end else if (emit_close) begin
         rsp_in.resend_valid  = 1'b0;
         rsp_in.seq_out       = '0;
         rsp_in.tag_out       = '0;
         rsp_in.attempt       = '0;
         rsp_in.status        = status_ff;
         rsp_in.removed_count = (removed_wide > 32'(REMOVED_MAX))
                                ? REMOVED_W'(REMOVED_MAX) : removed_wide[REMOVED_W-1:0];
         rsp_in.last          = 1'b1;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         timeout_ff     <= TIMEOUT_RESET;
         max_resends_ff <= MAX_RESENDS_RESET;
         fill_ff        <= '0;
         step_ff        <= '0;
         removed_ff     <= '0;
         status_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         timeout_ff     <= timeout_in;
         max_resends_ff <= max_resends_in;
         fill_ff        <= fill_in;
         step_ff        <= step_in;
         removed_ff     <= removed_in;
         status_ff      <= status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept) begin
         seq_ff <= req_ch.seq;
         tag_ff <= req_ch.packet_tag;
         now_ff <= req_ch.now_ms;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.resend_valid  = rsp_ff.resend_valid;
   assign rsp_ch.seq_out       = rsp_ff.seq_out;
   assign rsp_ch.tag_out       = rsp_ff.tag_out;
   assign rsp_ch.attempt       = rsp_ff.attempt;
   assign rsp_ch.status        = rsp_ff.status;
   assign rsp_ch.removed_count = rsp_ff.removed_count;
   assign rsp_ch.last          = rsp_ff.last;

endmodule

>>> tb/tb_ack_retransmit_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ack_retransmit_table
// Self-checking bench for the acknowledgement retransmission table. A short
// directed table (unused code, empty table, fill to overflow, wrapped and
// future timestamps) runs first, then random track/ack/scan traffic under
// several timeout and resend-limit settings with random idling on both sides.
// Every response beat is checked against a software copy of the table.
// ----------------------------------------------------------------------------
module tb_ack_retransmit_table;
   import ack_rt_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
   localparam int OWED_DEPTH    = 8192;
   localparam int ROW_DEPTH     = 32;

   typedef struct {
      action_type           act;
      logic [SEQ_W-1:0]     seq;
      logic [TAG_W-1:0]     tag;
      logic [TIME_W-1:0]    now;
      bit                   typed;
      logic                 status;
      logic [REMOVED_W-1:0] removed;
   } cmd_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ack_rt_req_if req_ch ();
   ack_rt_rsp_if rsp_ch ();

   ack_retransmit_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // software copy of the table and its registers
   body_type             shadow_tbl [ENTRIES];
   int                   live_count;
   logic [TIMEOUT_W-1:0] timeout_cfg;
   logic [RESENDS_W-1:0] limit_cfg;
   logic [TIME_W-1:0]    wall_ms;

   // expected beats in order, checked from owed_head up to owed_tail
   rsp_type     owed_beats [OWED_DEPTH];
   int          owed_head = 0;
   int          owed_tail = 0;
   cmd_row_type directed_rows [ROW_DEPTH];
   int          row_count = 0;

   int  fault_count  = 0;
   int  cmd_seen [4] = '{0, 0, 0, 0};
   int  resend_beats = 0;
   int  drop_beats   = 0;
   int  acked_total  = 0;
   int  settings_used = 1;
   int  send_idle    = 0;
   int  rsp_idle     = 0;
   bit  hold_ask     = 1'b0;
   int  hold_left    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_fault(string what, logic [31:0] got, logic [31:0] want);
      $display("fault: %s got 0x%0h expected 0x%0h at %0t ns", what, got, want, $time);
      fault_count++;
   endtask

   function automatic void owe_beat(rsp_type b);
      owed_beats[owed_tail] = b;
      owed_tail++;
   endfunction

   // applies one command to the shadow table, queues the beats it owes
   function automatic int table_apply(action_type act, logic [SEQ_W-1:0] s,
                                      logic [TAG_W-1:0] tg, logic [TIME_W-1:0] nw);
      rsp_type          beat;
      rsp_type          hit;
      int               n;
      int               keep;
      int               gone;
      int               i;
      logic [TIME_W-1:0] elapsed;
      n    = 0;
      beat = '0;
      beat.last = 1'b1;
      case (act)
         ACT_TRACK: begin
            if (live_count >= ENTRIES) begin
               beat.status = 1'b1;
               drop_beats++;
            end else begin
               shadow_tbl[live_count].seq     = s;
               shadow_tbl[live_count].tag     = tg;
               shadow_tbl[live_count].sent    = nw;
               shadow_tbl[live_count].resends = '0;
               live_count++;
            end
         end
         ACT_ACK: begin
            keep = 0;
            gone = 0;
            for (i = 0; i < live_count; i++) begin
               if (shadow_tbl[i].seq == s) begin
                  gone++;
               end else begin
                  shadow_tbl[keep] = shadow_tbl[i];
                  keep++;
               end
            end
            live_count = keep;
            acked_total += gone;
            beat.removed_count = REMOVED_W'((gone > REMOVED_MAX) ? REMOVED_MAX : gone);
         end
         ACT_SCAN: begin
            for (i = 0; i < live_count; i++) begin
               elapsed = nw - shadow_tbl[i].sent;
               if (elapsed > TIME_W'(timeout_cfg) && shadow_tbl[i].resends < limit_cfg) begin
                  shadow_tbl[i].sent    = nw;
                  shadow_tbl[i].resends = shadow_tbl[i].resends + RESENDS_W'(1);
                  hit = '0;
                  hit.resend_valid = 1'b1;
                  hit.seq_out      = shadow_tbl[i].seq;
                  hit.tag_out      = shadow_tbl[i].tag;
                  hit.attempt      = shadow_tbl[i].resends;
                  owe_beat(hit);
                  n++;
               end
            end
         end
         default: begin
         end
      endcase
      owe_beat(beat);
      return n + 1;
   endfunction

   // offers one command; entered and left at a falling edge
   task automatic send_beat(action_type act, logic [SEQ_W-1:0] s, logic [TAG_W-1:0] tg,
                            logic [TIME_W-1:0] nw, bit typed, logic st,
                            logic [REMOVED_W-1:0] rm);
      rsp_type fixed;
      int      n;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.seq        <= s;
      req_ch.packet_tag <= tg;
      req_ch.now_ms     <= nw;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      cmd_seen[act]++;
      n = table_apply(act, s, tg, nw);
      if (typed && n == 1) begin
         fixed = '0;
         fixed.status        = st;
         fixed.removed_count = rm;
         fixed.last          = 1'b1;
         owed_beats[owed_tail - 1] = fixed;
      end
      @(negedge clock);
   endtask

   function automatic logic [SEQ_W-1:0] pick_seq();
      int p;
      p = $urandom_range(99);
      if (p < 40 && live_count > 0) return shadow_tbl[$urandom_range(live_count - 1)].seq;
      if (p < 85) return SEQ_W'($urandom_range(7));
      return $urandom;
   endfunction

   function automatic logic [TIME_W-1:0] pick_now();
      int p;
      p = $urandom_range(99);
      if (p < 5) begin
         wall_ms = $urandom;
      end else if (p < 15 && live_count > 0) begin
         // land right on the timeout boundary of some entry
         wall_ms = shadow_tbl[$urandom_range(live_count - 1)].sent + TIME_W'(timeout_cfg)
                   + TIME_W'($urandom_range(3)) - TIME_W'(1);
      end else if (p < 23) begin
         wall_ms = wall_ms + TIME_W'($urandom_range(200000));
      end else if (p < 27) begin
         // step back so entries look stamped in the future
         wall_ms = wall_ms - TIME_W'($urandom_range(1000));
      end else begin
         wall_ms = wall_ms + TIME_W'($urandom_range(timeout_cfg / 8 + 4));
      end
      return wall_ms;
   endfunction

   task automatic random_burst(int count);
      action_type act;
      int         p;
      repeat (count) begin
         p = $urandom_range(99);
         if (p < 45)      act = ACT_TRACK;
         else if (p < 60) act = ACT_ACK;
         else if (p < 93) act = ACT_SCAN;
         else             act = ACT_NONE;
         send_beat(act, pick_seq(), TAG_W'($urandom), pick_now(), 1'b0, 1'b0, '0);
      end
   endtask

   task automatic settle_table();
      req_ch.valid <= 1'b0;
      while (owed_tail != owed_head) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic next_setting(logic [CSR_DATA_W-1:0] tmo, logic [CSR_DATA_W-1:0] lim_word,
                               int s_idle, int r_idle);
      settle_table();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= tmo;
      @(negedge clock);
      csr_index <= CSR_MAX_RESENDS;
      csr_wdata <= lim_word;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      timeout_cfg = tmo;
      limit_cfg   = lim_word[RESENDS_W-1:0];
      send_idle   = s_idle;
      rsp_idle    = r_idle;
      settings_used++;
   endtask

   function automatic void add_row(action_type act, logic [SEQ_W-1:0] s, logic [TAG_W-1:0] tg,
                                   logic [TIME_W-1:0] nw, bit typed, logic st,
                                   logic [REMOVED_W-1:0] rm);
      directed_rows[row_count] = '{act, s, tg, nw, typed, st, rm};
      row_count++;
   endfunction

   // response side: random back-pressure plus the long hold-off
   always @(negedge clock) begin
      if (hold_ask) begin
         hold_ask  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (owed_head == owed_tail) begin
            flag_fault("beat with nothing owed, seq_out", rsp_ch.seq_out, '0);
         end else begin
            want = owed_beats[owed_head];
            owed_head++;
            if (rsp_ch.resend_valid !== want.resend_valid)
               flag_fault("resend_valid", 32'(rsp_ch.resend_valid), 32'(want.resend_valid));
            if (rsp_ch.seq_out !== want.seq_out)
               flag_fault("seq_out", rsp_ch.seq_out, want.seq_out);
            if (rsp_ch.tag_out !== want.tag_out)
               flag_fault("tag_out", 32'(rsp_ch.tag_out), 32'(want.tag_out));
            if (rsp_ch.attempt !== want.attempt)
               flag_fault("attempt", 32'(rsp_ch.attempt), 32'(want.attempt));
            if (rsp_ch.status !== want.status)
               flag_fault("status", 32'(rsp_ch.status), 32'(want.status));
            if (rsp_ch.removed_count !== want.removed_count)
               flag_fault("removed_count", 32'(rsp_ch.removed_count),
                          32'(want.removed_count));
            if (rsp_ch.last !== want.last)
               flag_fault("last", 32'(rsp_ch.last), 32'(want.last));
            if (want.resend_valid) resend_beats++;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("run timed out with %0d beats still owed", owed_tail - owed_head);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      csr_wr_en         = 1'b0;
      csr_index         = CSR_TIMEOUT;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_TRACK;
      req_ch.seq        = '0;
      req_ch.packet_tag = '0;
      req_ch.now_ms     = '0;
      rsp_ch.ready      = 1'b0;
      timeout_cfg       = TIMEOUT_RESET;
      limit_cfg         = MAX_RESENDS_RESET;
      live_count        = 0;
      wall_ms           = $urandom;

      // empty table, unused code, then fill past the end
      add_row(ACT_NONE, '1, '1, '1, 1'b1, 1'b0, '0);
      add_row(ACT_SCAN, '0, '0, '0, 1'b1, 1'b0, '0);
      add_row(ACT_ACK,  '0, '0, '0, 1'b1, 1'b0, '0);
      add_row(ACT_TRACK, '1, '1, '1, 1'b1, 1'b0, '0);
      for (int k = 0; k < ENTRIES - 1; k++) begin
         add_row(ACT_TRACK, SEQ_W'(k % 4), TAG_W'(16'h1000 + k),
                 (k >= 12) ? TIME_W'(32'h8000_0000 + k) : TIME_W'(k * 7), 1'b1, 1'b0, '0);
      end
      add_row(ACT_TRACK, SEQ_W'(9), TAG_W'(16'h00aa), TIME_W'(50), 1'b1, 1'b1, '0);
      // wrapped stamp just past the timeout, plain stamp exactly on it
      add_row(ACT_SCAN, '0, '0, TIME_W'(100), 1'b0, 1'b0, '0);
      add_row(ACT_SCAN, '0, '0, TIME_W'(32'h8000_0000), 1'b0, 1'b0, '0);
      add_row(ACT_ACK,  '0, '0, '0, 1'b0, 1'b0, '0);
      add_row(ACT_ACK,  '1, '0, '0, 1'b0, 1'b0, '0);
      add_row(ACT_SCAN, '0, '0, '0, 1'b0, 1'b0, '0);

      send_idle = 20;
      rsp_idle  = 75;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < row_count; r++) begin
         send_beat(directed_rows[r].act, directed_rows[r].seq, directed_rows[r].tag,
                   directed_rows[r].now, directed_rows[r].typed, directed_rows[r].status,
                   directed_rows[r].removed);
      end

      next_setting(16'd0, {13'($urandom), 3'd7}, 20, 75);
      random_burst(40);

      // long response stall while commands keep coming
      next_setting(TIMEOUT_RESET, 16'(MAX_RESENDS_RESET), 20, 75);
      hold_ask = 1'b1;
      random_burst(14);

      next_setting(16'hffff, 16'd0, 75, 20);
      random_burst(35);

      next_setting(16'($urandom_range(1, 300)), 16'($urandom_range(1, 6)), 75, 20);
      random_burst(30);

      next_setting(16'($urandom_range(0, 2000)), 16'd7, 0, 0);
      random_burst(30);

      settle_table();
      $display("ran %0d tracks, %0d acks, %0d scans, %0d unused codes over %0d settings",
               cmd_seen[ACT_TRACK], cmd_seen[ACT_ACK], cmd_seen[ACT_SCAN],
               cmd_seen[ACT_NONE], settings_used);
      $display("saw %0d resends, %0d dropped tracks, %0d entries acked, %0d faults",
               resend_beats, drop_beats, acked_total, fault_count);
      if (fault_count == 0 && owed_head == owed_tail) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
